// ----- design/pwows_pkg.sv -----
// ----------------------------------------------------------------------------
// pwows_pkg
// Shared types and constants of the pulse-width one-wire sender.
// ----------------------------------------------------------------------------
package pwows_pkg;

	localparam int WORD_BITS   = 16;
	localparam int HALF_BITS   = WORD_BITS / 2;
	localparam int BITS_CNT_W  = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] VOL_BASE      = 16'hFFE0;
	localparam logic [15:0] VOL_MAX_PCT   = 16'd100;
	localparam logic [3:0]  VOL_MAX_LEVEL = 4'd15;
	// percent * 15 / 100 as percent * 9840 >> 16, exact for 0..100
	localparam logic [13:0] VOL_RECIP     = 14'd9840;

	localparam logic [15:0] RST_SHORT     = 16'd65;
	localparam logic [15:0] RST_LONG      = 16'd195;
	localparam logic [15:0] RST_LEAD_HIGH = 16'd6000;
	localparam logic [15:0] RST_LEAD_LOW  = 16'd6000;
	localparam logic [15:0] RST_GAP_HIGH  = 16'd3000;
	localparam logic [15:0] RST_GAP_LOW   = 16'd6000;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_WORD   = 2'd1,
		CMD_VOLUME = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT     = 3'd0,
		REG_LONG      = 3'd1,
		REG_LEAD_HIGH = 3'd2,
		REG_LEAD_LOW  = 3'd3,
		REG_GAP_HIGH  = 3'd4,
		REG_GAP_LOW   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NOP   = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_LEAD_HIGH = 3'd1,
		PH_LEAD_LOW  = 3'd2,
		PH_BIT_HIGH  = 3'd3,
		PH_BIT_LOW   = 3'd4,
		PH_GAP_HIGH  = 3'd5,
		PH_GAP_LOW   = 3'd6
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] word;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

// ----- design/pwows_if.sv -----
// ----------------------------------------------------------------------------
// pwows_if
// Channel interfaces of the pulse-width one-wire sender.
// ----------------------------------------------------------------------------
interface pwows_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] word;
	logic signed [15:0] volume_percent;

	modport source (output valid, cmd, word, volume_percent, input ready);
	modport sink   (input valid, cmd, word, volume_percent, output ready);
endinterface

interface pwows_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic sending;
	logic frame_done;
	logic start_rejected;

	modport source (output valid, line_level, sending, frame_done, start_rejected,
		input ready);
	modport sink   (input valid, line_level, sending, frame_done, start_rejected,
		output ready);
endinterface

interface pwows_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/pwows_front.sv -----
// ----------------------------------------------------------------------------
// pwows_front
// Classifies input items and builds the frame word for start items.
// ----------------------------------------------------------------------------
module pwows_front (
	input  logic [1:0]         cmd,
	input  logic [15:0]        word,
	input  logic signed [15:0] volume_percent,
	output pwows_pkg::item_t   item
);

	logic [20:0] vol_prod;
	logic [3:0]  vol_level;

	always_comb begin
		vol_prod = 21'({7'(volume_percent[6:0])} * {7'd0, pwows_pkg::VOL_RECIP});
		if (!volume_percent[15] && (volume_percent > $signed(pwows_pkg::VOL_MAX_PCT))) begin
			vol_level = pwows_pkg::VOL_MAX_LEVEL;
		end else if (volume_percent[15]) begin
			vol_level = 4'd0;
		end else begin
			vol_level = vol_prod[19:16];
		end
	end

	always_comb begin
		case (pwows_pkg::cmd_t'(cmd))
			pwows_pkg::CMD_TICK: begin
				item.kind = pwows_pkg::KIND_TICK;
				item.word = word;
			end
			pwows_pkg::CMD_WORD: begin
				item.kind = pwows_pkg::KIND_START;
				item.word = word;
			end
			pwows_pkg::CMD_VOLUME: begin
				item.kind = pwows_pkg::KIND_START;
				item.word = pwows_pkg::VOL_BASE + {12'd0, vol_level};
			end
			default: begin
				item.kind = pwows_pkg::KIND_NOP;
				item.word = word;
			end
		endcase
	end

endmodule

// ----- design/pwows_queue.sv -----
// ----------------------------------------------------------------------------
// pwows_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module pwows_queue #(
	parameter int DEPTH = pwows_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  pwows_pkg::item_t         push_item,
	output logic                     full,
	input  logic                     pop,
	output pwows_pkg::queue_head_t   head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pwows_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == FULL_CNT);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- design/pwows_back.sv -----
// ----------------------------------------------------------------------------
// pwows_back
// Frame sequencer, timing registers and result register.
// ----------------------------------------------------------------------------
module pwows_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pwows_pkg::queue_head_t head,
	output logic                   pop,
	pwows_cfg_if.sink              cfg,
	pwows_out_if.source            rsp
);

	logic [15:0] short_q, long_q, lead_high_q, lead_low_q, gap_high_q, gap_low_q;

	pwows_pkg::phase_t                  phase_q, phase_d;
	logic [15:0]                        tick_q, tick_d;
	logic [15:0]                        shift_q, shift_d;
	logic [pwows_pkg::BITS_CNT_W-1:0]   bits_q, bits_d, bits_inc;
	logic                               line_q, line_d;
	logic                               done_d, rejected_d;

	logic [15:0] seg_ticks;
	logic        seg_end;
	logic        is_tick, is_start, busy;

	logic out_valid_q, out_line_q, out_sending_q, out_done_q, out_rejected_q;

	assign pop       = head.valid && (!out_valid_q || rsp.ready);
	assign busy      = (phase_q != pwows_pkg::PH_IDLE);
	assign is_tick   = pop && (head.item.kind == pwows_pkg::KIND_TICK);
	assign is_start  = pop && (head.item.kind == pwows_pkg::KIND_START);
	assign bits_inc  = bits_q + pwows_pkg::BITS_CNT_W'(1);
	assign seg_end   = ({1'b0, tick_q} + 17'd1) >= {1'b0, seg_ticks};

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q     <= pwows_pkg::RST_SHORT;
			long_q      <= pwows_pkg::RST_LONG;
			lead_high_q <= pwows_pkg::RST_LEAD_HIGH;
			lead_low_q  <= pwows_pkg::RST_LEAD_LOW;
			gap_high_q  <= pwows_pkg::RST_GAP_HIGH;
			gap_low_q   <= pwows_pkg::RST_GAP_LOW;
		end else if (cfg.valid) begin
			case (pwows_pkg::reg_idx_t'(cfg.index))
				pwows_pkg::REG_SHORT:     short_q     <= cfg.data;
				pwows_pkg::REG_LONG:      long_q      <= cfg.data;
				pwows_pkg::REG_LEAD_HIGH: lead_high_q <= cfg.data;
				pwows_pkg::REG_LEAD_LOW:  lead_low_q  <= cfg.data;
				pwows_pkg::REG_GAP_HIGH:  gap_high_q  <= cfg.data;
				pwows_pkg::REG_GAP_LOW:   gap_low_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (phase_q)
			pwows_pkg::PH_LEAD_HIGH: seg_ticks = lead_high_q;
			pwows_pkg::PH_LEAD_LOW:  seg_ticks = lead_low_q;
			pwows_pkg::PH_GAP_HIGH:  seg_ticks = gap_high_q;
			pwows_pkg::PH_GAP_LOW:   seg_ticks = gap_low_q;
			pwows_pkg::PH_BIT_HIGH:  seg_ticks = shift_q[0] ? long_q : short_q;
			pwows_pkg::PH_BIT_LOW:   seg_ticks = shift_q[0] ? short_q : long_q;
			default:                 seg_ticks = 16'd1;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (is_start && !busy) begin
			phase_d = pwows_pkg::PH_LEAD_HIGH;
		end else if (is_tick && busy && seg_end) begin
			case (phase_q)
				pwows_pkg::PH_LEAD_HIGH: phase_d = pwows_pkg::PH_LEAD_LOW;
				pwows_pkg::PH_LEAD_LOW:  phase_d = pwows_pkg::PH_BIT_HIGH;
				pwows_pkg::PH_GAP_LOW:   phase_d = pwows_pkg::PH_BIT_HIGH;
				pwows_pkg::PH_BIT_HIGH:  phase_d = pwows_pkg::PH_BIT_LOW;
				pwows_pkg::PH_GAP_HIGH:  phase_d = pwows_pkg::PH_GAP_LOW;
				pwows_pkg::PH_BIT_LOW: begin
					if (bits_inc >= pwows_pkg::BITS_CNT_W'(pwows_pkg::WORD_BITS)) begin
						phase_d = pwows_pkg::PH_IDLE;
					end else if (bits_inc == pwows_pkg::BITS_CNT_W'(pwows_pkg::HALF_BITS)) begin
						phase_d = pwows_pkg::PH_GAP_HIGH;
					end else begin
						phase_d = pwows_pkg::PH_BIT_HIGH;
					end
				end
				default: phase_d = pwows_pkg::PH_IDLE;
			endcase
		end
	end

	// datapath and flags
	always_comb begin
		tick_d     = tick_q;
		shift_d    = shift_q;
		bits_d     = bits_q;
		line_d     = line_q;
		done_d     = 1'b0;
		rejected_d = 1'b0;
		if (is_start) begin
			if (busy) begin
				rejected_d = 1'b1;
			end else begin
				// high byte first, each byte lsb first
				shift_d = {head.item.word[7:0], head.item.word[15:8]};
				bits_d  = '0;
				tick_d  = '0;
				line_d  = 1'b1;
			end
		end else if (is_tick && busy) begin
			if (!seg_end) begin
				tick_d = tick_q + 16'd1;
			end else begin
				tick_d = '0;
				case (phase_q)
					pwows_pkg::PH_LEAD_HIGH,
					pwows_pkg::PH_BIT_HIGH,
					pwows_pkg::PH_GAP_HIGH: line_d = 1'b0;
					pwows_pkg::PH_LEAD_LOW,
					pwows_pkg::PH_GAP_LOW:  line_d = 1'b1;
					pwows_pkg::PH_BIT_LOW: begin
						shift_d = {1'b0, shift_q[15:1]};
						bits_d  = bits_inc;
						line_d  = 1'b1;
						done_d  = (bits_inc >= pwows_pkg::BITS_CNT_W'(pwows_pkg::WORD_BITS));
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pwows_pkg::PH_IDLE;
			tick_q  <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			line_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			line_q  <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_line_q     <= line_d;
			out_sending_q  <= (phase_d != pwows_pkg::PH_IDLE);
			out_done_q     <= done_d;
			out_rejected_q <= rejected_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.line_level     = out_line_q;
	assign rsp.sending        = out_sending_q;
	assign rsp.frame_done     = out_done_q;
	assign rsp.start_rejected = out_rejected_q;

endmodule

// ----- design/pulse_width_one_wire_sender_top.sv -----
// ----------------------------------------------------------------------------
// pulse_width_one_wire_sender_top
// Pulse-width one-wire sender advanced by tick items.
//
//   channel  role    payload
//   req      sink    cmd, word, volume_percent
//   rsp      source  line_level, sending, frame_done, start_rejected
//   cfg      sink    index, data (always ready)
//
// one item per cycle sustained while rsp is ready; a result reaches rsp after its transfer
// via decode into the queue at the transfer, then the sequencer into the result register
// rsp stalls fill the queue, then req.ready drops; configuration is never stalled
// asynchronous reset loads the timing registers with their defaults
// ----------------------------------------------------------------------------
module pulse_width_one_wire_sender_top #(
	parameter int QUEUE_DEPTH = pwows_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	pwows_in_if.sink     req,
	pwows_out_if.source  rsp,
	pwows_cfg_if.sink    cfg
);

	pwows_pkg::item_t       item;
	pwows_pkg::queue_head_t head;
	logic                   full;
	logic                   pop;
	logic                   push;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	pwows_front u_front (
		.cmd            (req.cmd),
		.word           (req.word),
		.volume_percent (req.volume_percent),
		.item           (item)
	);

	pwows_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.full      (full),
		.pop       (pop),
		.head      (head)
	);

	pwows_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.cfg    (cfg),
		.rsp    (rsp)
	);

endmodule
